### rtl/exlex_pkg.sv
// Shared types, token codes and helper functions for the expression lexer.
package exlex_pkg;

    // Default build parameters.
    localparam int FRAC_DIGITS_DEF   = 5;
    localparam int POSITION_BITS_DEF = 24;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // Fixed field widths of the token channel.
    localparam int TEXT_W  = 24;
    localparam int LEN_W   = 16;
    localparam int LINE_W  = 16;
    localparam int INT_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int VALUE_W = INT_W + FRAC_W;
    localparam int KIND_W  = 4;

    // Decimal fraction digits are held in binary, at most nine digits.
    localparam int FV_W   = 30;
    localparam int FDIG_W = 4;

    // Fraction conversion: four quotient bits per cycle.
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = FRAC_W / DIV_STEPS;
    localparam int DIVC_W     = $clog2(DIV_CYCLES + 1);

    // Token kinds.
    localparam logic [KIND_W-1:0] K_MUL    = 4'd0;
    localparam logic [KIND_W-1:0] K_PLUS   = 4'd1;
    localparam logic [KIND_W-1:0] K_MINUS  = 4'd2;
    localparam logic [KIND_W-1:0] K_DIV    = 4'd3;
    localparam logic [KIND_W-1:0] K_LPAREN = 4'd4;
    localparam logic [KIND_W-1:0] K_RPAREN = 4'd5;
    localparam logic [KIND_W-1:0] K_EQUAL  = 4'd6;
    localparam logic [KIND_W-1:0] K_COMMA  = 4'd7;
    localparam logic [KIND_W-1:0] K_NUMBER = 4'd8;
    localparam logic [KIND_W-1:0] K_IDENT  = 4'd9;
    localparam logic [KIND_W-1:0] K_DEBUG  = 4'd10;
    localparam logic [KIND_W-1:0] K_END    = 4'd11;
    localparam logic [KIND_W-1:0] K_EMPTY  = 4'd12;

    // Keyword "@debug".
    localparam logic [2:0] KW_LEN = 3'd6;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_INT     = 3'd1,
        MODE_FRAC    = 3'd2,
        MODE_IDENT   = 3'd3,
        MODE_COMMENT = 3'd4
    } mode_t;

    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] kind;
    } op_t;

    // Tokens caused by one source byte: a finished pending token, a token of
    // this byte alone, and the end token, in that order.
    typedef struct packed {
        logic              s1_v;
        logic [KIND_W-1:0] s1_kind;
        logic [INT_W-1:0]  s1_int;
        logic [FV_W-1:0]   s1_frac;
        logic [FDIG_W-1:0] s1_fdig;
        logic [TEXT_W-1:0] s1_start;
        logic [LEN_W-1:0]  s1_len;
        logic              s2_v;
        logic [KIND_W-1:0] s2_kind;
        logic [3:0]        s2_digit;
        logic [TEXT_W-1:0] s2_start;
        logic              s3_v;
        logic [KIND_W-1:0] s3_kind;
        logic [TEXT_W-1:0] s3_start;
        logic [LINE_W-1:0] s3_line;
        logic [LINE_W-1:0] line;
    } rec_t;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = "@";
            3'd1:    c = "d";
            3'd2:    c = "e";
            3'd3:    c = "b";
            3'd4:    c = "u";
            3'd5:    c = "g";
            default: c = 8'd0;
        endcase
        kw_char = c;
    endfunction

    function automatic op_t op_lookup(input logic [7:0] c);
        op_t r;
        r.hit = 1'b1;
        unique case (c)
            "*":     r.kind = K_MUL;
            "+":     r.kind = K_PLUS;
            "-":     r.kind = K_MINUS;
            "/":     r.kind = K_DIV;
            "(":     r.kind = K_LPAREN;
            ")":     r.kind = K_RPAREN;
            "=":     r.kind = K_EQUAL;
            ",":     r.kind = K_COMMA;
            default:
            begin
                r.hit  = 1'b0;
                r.kind = K_MUL;
            end
        endcase
        op_lookup = r;
    endfunction

    function automatic logic [FV_W-1:0] pow10(input logic [FDIG_W-1:0] d);
        logic [FV_W-1:0] p;
        unique case (d)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        pow10 = p;
    endfunction

endpackage

### rtl/exlex_front.sv
// Scanner front end: takes one source byte per beat and builds token records.
module exlex_front import exlex_pkg::*; #(
    parameter int FRAC_DIGITS   = FRAC_DIGITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_in,
    input  logic       is_last,
    input  logic       empty_input,
    output logic       push_valid,
    input  logic       push_ready,
    output rec_t       push_data
);

    mode_t                    mode_reg, mode_next;
    logic [INT_W-1:0]         acc_reg, acc_next;
    logic [FV_W-1:0]          frac_reg, frac_next;
    logic [FDIG_W-1:0]        fdig_reg, fdig_next;
    logic [POSITION_BITS-1:0] tstart_reg, tstart_next;
    logic [LEN_W-1:0]         tlen_reg, tlen_next;
    logic [LINE_W-1:0]        line_reg, line_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [2:0]               kw_idx_reg, kw_idx_next;
    logic                     kw_ok_reg, kw_ok_next;
    logic                     seen_reg, seen_next;

    logic       accept;
    logic       brk;
    logic       newtok;
    logic       is_dig, is_alpha, is_id_start, is_id_char;
    logic [3:0] digit;
    op_t        op;
    logic [INT_W+3:0] acc_wide;
    logic [FV_W+3:0]  frac_wide;
    logic [INT_W-1:0] acc_step;
    rec_t       rec;

    assign accept   = in_valid && in_ready;
    assign in_ready = push_ready;

    // Character classes.
    assign digit       = byte_in[3:0];
    assign is_dig      = (byte_in >= "0") && (byte_in <= "9");
    assign is_alpha    = ((byte_in >= "a") && (byte_in <= "z")) ||
                         ((byte_in >= "A") && (byte_in <= "Z"));
    assign is_id_start = is_alpha || (byte_in == "_") || (byte_in == "@");
    assign is_id_char  = is_id_start || is_dig;
    assign op          = op_lookup(byte_in);

    // Decimal accumulation by shift and add; the integer part saturates.
    assign acc_wide  = (INT_W+4)'({acc_reg, 3'b000}) + (INT_W+4)'({acc_reg, 1'b0})
                     + (INT_W+4)'(digit);
    assign acc_step  = (acc_wide[INT_W+3:INT_W] != 4'd0) ? '1 : acc_wide[INT_W-1:0];
    assign frac_wide = (FV_W+4)'({frac_reg, 3'b000}) + (FV_W+4)'({frac_reg, 1'b0})
                     + (FV_W+4)'(digit);

    // Scanner next state and token record.
    always_comb
    begin
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        frac_next   = frac_reg;
        fdig_next   = fdig_reg;
        tstart_next = tstart_reg;
        tlen_next   = tlen_reg;
        line_next   = line_reg;
        pos_next    = pos_reg;
        kw_idx_next = kw_idx_reg;
        kw_ok_next  = kw_ok_reg;
        seen_next   = seen_reg;
        brk         = 1'b0;
        newtok      = 1'b0;
        rec         = '0;
        rec.line    = line_reg;

        if (empty_input && !seen_reg)
        begin
            rec.s3_v     = 1'b1;
            rec.s3_kind  = K_EMPTY;
            rec.s3_start = '0;
            rec.s3_line  = 16'd1;
        end
        else
        begin
            if (!empty_input)
            begin
                pos_next  = pos_reg + 1'b1;
                seen_next = 1'b1;

                // Continue the pending token or find that it ends here.
                unique case (mode_reg)
                    MODE_INT:
                    begin
                        if (is_dig)
                        begin
                            acc_next  = acc_step;
                            tlen_next = sat_inc16(tlen_reg);
                        end
                        else if (byte_in == ".")
                        begin
                            mode_next = MODE_FRAC;
                            tlen_next = sat_inc16(tlen_reg);
                        end
                        else
                        begin
                            brk = 1'b1;
                        end
                    end
                    MODE_FRAC:
                    begin
                        if (is_dig)
                        begin
                            if (fdig_reg < FDIG_W'(FRAC_DIGITS))
                            begin
                                frac_next = frac_wide[FV_W-1:0];
                                fdig_next = fdig_reg + 1'b1;
                            end
                            tlen_next = sat_inc16(tlen_reg);
                        end
                        else
                        begin
                            brk = 1'b1;
                        end
                    end
                    MODE_IDENT:
                    begin
                        if (is_id_char)
                        begin
                            if (kw_idx_reg < KW_LEN)
                            begin
                                if (byte_in != kw_char(kw_idx_reg))
                                begin
                                    kw_ok_next = 1'b0;
                                end
                                kw_idx_next = kw_idx_reg + 1'b1;
                            end
                            else
                            begin
                                kw_ok_next = 1'b0;
                            end
                            tlen_next = sat_inc16(tlen_reg);
                        end
                        else
                        begin
                            brk = 1'b1;
                        end
                    end
                    MODE_COMMENT:
                    begin
                        if (byte_in == 8'h0A)
                        begin
                            mode_next = MODE_IDLE;
                            line_next = sat_inc16(line_reg);
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                    end
                endcase

                // The pending token is finished by this byte.
                if (brk)
                begin
                    rec.s1_v     = 1'b1;
                    rec.s1_kind  = (mode_reg == MODE_IDENT) ?
                                   ((kw_ok_reg && kw_idx_reg == KW_LEN) ? K_DEBUG : K_IDENT) :
                                   K_NUMBER;
                    rec.s1_int   = acc_reg;
                    rec.s1_frac  = frac_reg;
                    rec.s1_fdig  = fdig_reg;
                    rec.s1_start = TEXT_W'(tstart_reg);
                    rec.s1_len   = tlen_reg;
                    mode_next    = MODE_IDLE;
                end

                // Classify the byte from the idle state.
                if (mode_reg == MODE_IDLE || brk)
                begin
                    if (op.hit)
                    begin
                        rec.s2_v     = 1'b1;
                        rec.s2_kind  = op.kind;
                        rec.s2_start = TEXT_W'(pos_reg);
                    end
                    else if (byte_in == 8'h0A)
                    begin
                        line_next = sat_inc16(line_reg);
                    end
                    else if (byte_in == "#")
                    begin
                        mode_next = MODE_COMMENT;
                    end
                    else if (is_dig)
                    begin
                        newtok      = 1'b1;
                        mode_next   = MODE_INT;
                        acc_next    = INT_W'(digit);
                        frac_next   = '0;
                        fdig_next   = '0;
                        tstart_next = pos_reg;
                        tlen_next   = 16'd1;
                    end
                    else if (is_id_start)
                    begin
                        newtok      = 1'b1;
                        mode_next   = MODE_IDENT;
                        tstart_next = pos_reg;
                        tlen_next   = 16'd1;
                        kw_ok_next  = (byte_in == "@");
                        kw_idx_next = 3'd1;
                    end
                end
            end

            // End of source: flush the pending token and close with an end token.
            if (is_last || empty_input)
            begin
                if (newtok)
                begin
                    rec.s2_v     = 1'b1;
                    rec.s2_kind  = (mode_next == MODE_INT) ? K_NUMBER : K_IDENT;
                    rec.s2_digit = digit;
                    rec.s2_start = TEXT_W'(pos_reg);
                end
                else if (mode_next == MODE_INT || mode_next == MODE_FRAC ||
                         mode_next == MODE_IDENT)
                begin
                    rec.s1_v     = 1'b1;
                    rec.s1_kind  = (mode_next == MODE_IDENT) ?
                                   ((kw_ok_next && kw_idx_next == KW_LEN) ? K_DEBUG : K_IDENT) :
                                   K_NUMBER;
                    rec.s1_int   = acc_next;
                    rec.s1_frac  = frac_next;
                    rec.s1_fdig  = fdig_next;
                    rec.s1_start = TEXT_W'(tstart_next);
                    rec.s1_len   = tlen_next;
                end
                rec.s3_v     = 1'b1;
                rec.s3_kind  = K_END;
                rec.s3_start = TEXT_W'(pos_next);
                rec.s3_line  = line_next;
            end
        end

        // Back to the reset state after an end or empty token.
        if (empty_input || is_last)
        begin
            mode_next   = MODE_IDLE;
            acc_next    = '0;
            frac_next   = '0;
            fdig_next   = '0;
            tstart_next = '0;
            tlen_next   = '0;
            line_next   = 16'd1;
            pos_next    = '0;
            kw_idx_next = '0;
            kw_ok_next  = 1'b1;
            seen_next   = 1'b0;
        end
    end

    assign push_valid = accept && (rec.s1_v || rec.s2_v || rec.s3_v);
    assign push_data  = rec;

    // Scanner state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            acc_reg    <= '0;
            frac_reg   <= '0;
            fdig_reg   <= '0;
            tstart_reg <= '0;
            tlen_reg   <= '0;
            line_reg   <= 16'd1;
            pos_reg    <= '0;
            kw_idx_reg <= '0;
            kw_ok_reg  <= 1'b1;
            seen_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            acc_reg    <= acc_next;
            frac_reg   <= frac_next;
            fdig_reg   <= fdig_next;
            tstart_reg <= tstart_next;
            tlen_reg   <= tlen_next;
            line_reg   <= line_next;
            pos_reg    <= pos_next;
            kw_idx_reg <= kw_idx_next;
            kw_ok_reg  <= kw_ok_next;
            seen_reg   <= seen_next;
        end
    end

endmodule

### rtl/exlex_queue.sv
// Short record queue between the scanner and the token emitter.
module exlex_queue import exlex_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  rec_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output rec_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rec_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer wrap and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/exlex_back.sv
// Token emitter: converts fractions and sends the tokens of each record in order.
module exlex_back import exlex_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  rec_t                pop_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [KIND_W-1:0]   token_kind,
    output logic [VALUE_W-1:0]  number_value,
    output logic [TEXT_W-1:0]   text_start,
    output logic [LEN_W-1:0]    text_length,
    output logic [LINE_W-1:0]   line_number,
    output logic                last_result
);

    rec_t              cur_reg;
    logic [2:0]        pend_reg, pend_next;
    logic [DIVC_W-1:0] divc_reg, divc_next;
    logic [FV_W-1:0]   rem_reg, rem_next;
    logic [FRAC_W-1:0] quo_reg, quo_next;

    logic               out_valid_reg;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [TEXT_W-1:0]  start_reg, start_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LINE_W-1:0]  line_reg, line_next;
    logic               lastr_reg, lastr_next;

    logic              out_free;
    logic              emit;
    logic              done;
    logic              load;
    logic [2:0]        pend_after;
    logic [FV_W-1:0]   divisor;
    logic [FV_W:0]     div_r;
    logic [FRAC_W-1:0] div_q;

    assign out_free = !out_valid_reg || out_ready;
    assign divisor  = pow10(cur_reg.s1_fdig);

    // Token slot selection and output register contents.
    always_comb
    begin
        emit       = 1'b0;
        pend_after = pend_reg;
        kind_next  = cur_reg.s3_kind;
        value_next = '0;
        start_next = cur_reg.s3_start;
        len_next   = '0;
        line_next  = cur_reg.s3_line;
        priority if (pend_reg[0])
        begin
            emit          = (divc_reg == '0);
            pend_after[0] = 1'b0;
            kind_next     = cur_reg.s1_kind;
            value_next    = (cur_reg.s1_kind == K_NUMBER) ? {cur_reg.s1_int, quo_reg} : '0;
            start_next    = cur_reg.s1_start;
            len_next      = cur_reg.s1_len;
            line_next     = cur_reg.line;
        end
        else if (pend_reg[1])
        begin
            emit          = 1'b1;
            pend_after[1] = 1'b0;
            kind_next     = cur_reg.s2_kind;
            value_next    = (cur_reg.s2_kind == K_NUMBER) ?
                            {(INT_W-4)'(0), cur_reg.s2_digit, FRAC_W'(0)} : '0;
            start_next    = cur_reg.s2_start;
            len_next      = 16'd1;
            line_next     = cur_reg.line;
        end
        else if (pend_reg[2])
        begin
            emit          = 1'b1;
            pend_after[2] = 1'b0;
        end
        else
        begin
            emit = 1'b0;
        end
        emit       = emit && out_free;
        lastr_next = (pend_after == 3'b000);
    end

    assign done      = emit && (pend_after == 3'b000);
    assign pop_ready = (pend_reg == 3'b000) || done;
    assign load      = pop_valid && pop_ready;

    // Fraction conversion: restoring division, four quotient bits per cycle.
    always_comb
    begin
        div_r = {1'b0, rem_reg};
        div_q = quo_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            div_r = {div_r[FV_W-1:0], 1'b0};
            if (div_r >= {1'b0, divisor})
            begin
                div_r = div_r - {1'b0, divisor};
                div_q = {div_q[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                div_q = {div_q[FRAC_W-2:0], 1'b0};
            end
        end
    end

    // Record bookkeeping.
    always_comb
    begin
        pend_next = pend_reg;
        divc_next = divc_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (divc_reg != '0)
        begin
            divc_next = divc_reg - 1'b1;
            rem_next  = div_r[FV_W-1:0];
            quo_next  = div_q;
        end
        if (emit)
        begin
            pend_next = pend_after;
        end
        if (load)
        begin
            pend_next = {pop_data.s3_v, pop_data.s2_v, pop_data.s1_v};
            rem_next  = pop_data.s1_frac;
            quo_next  = '0;
            divc_next = (pop_data.s1_v && pop_data.s1_kind == K_NUMBER &&
                         pop_data.s1_fdig != '0) ? DIVC_W'(DIV_CYCLES) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            divc_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            divc_reg <= divc_next;
            if (out_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (load)
        begin
            cur_reg <= pop_data;
        end
        if (emit)
        begin
            kind_reg  <= kind_next;
            value_reg <= value_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            line_reg  <= line_next;
            lastr_reg <= lastr_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign token_kind   = kind_reg;
    assign number_value = value_reg;
    assign text_start   = start_reg;
    assign text_length  = len_reg;
    assign line_number  = line_reg;
    assign last_result  = lastr_reg;

endmodule

### rtl/expression_lexer.sv
// Expression lexer top level: scanner, record queue and token emitter.
//
// Source bytes enter on the input channel (in_valid/in_ready), one byte per
// beat with is_last marking the final byte; empty_input closes a source that
// carries no further byte, and on a source with no bytes at all it gives a
// single empty error token. Tokens leave on the output channel
// (out_valid/out_ready), one token per beat, last_result set on the final
// token caused by an input byte.
// Throughput: one input byte per cycle while the queue has room. The scanner
// classifies a byte combinationally and writes all tokens it causes (up to
// three) as one record into a QUEUE_DEPTH entry queue. The emitter sends one
// token per cycle while the receiver takes them; a number with fraction digits
// first waits in the restoring divider that forms its 16 fraction bits, which
// sets the rate on number-heavy source. A token passes through the queue and
// the emitter's record register before it reaches the output register.
// Reset clears the scanner to line 1, offset 0 and empties the queue and the
// output register. When the receiver stalls, the output register holds, the
// queue fills, and in_ready drops once the queue is full.
module expression_lexer import exlex_pkg::*; #(
    parameter int FRAC_DIGITS   = FRAC_DIGITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          byte_in,
    input  logic                is_last,
    input  logic                empty_input,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [KIND_W-1:0]   token_kind,
    output logic [VALUE_W-1:0]  number_value,
    output logic [TEXT_W-1:0]   text_start,
    output logic [LEN_W-1:0]    text_length,
    output logic [LINE_W-1:0]   line_number,
    output logic                last_result
);

    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    rec_t push_data, pop_data;

    exlex_front #(
        .FRAC_DIGITS   (FRAC_DIGITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_in     (byte_in),
        .is_last     (is_last),
        .empty_input (empty_input),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    exlex_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    exlex_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .number_value (number_value),
        .text_start   (text_start),
        .text_length  (text_length),
        .line_number  (line_number),
        .last_result  (last_result)
    );

`ifndef SYNTHESIS
    // The scanner never writes a record into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) push_valid |-> push_ready)
        else $error("record pushed into full queue");

    // End and empty error tokens always close the tokens of their byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind == K_END || token_kind == K_EMPTY)
        |-> last_result && text_length == '0)
        else $error("end token not last or has text");

    // Only number tokens carry a value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != K_NUMBER |-> number_value == '0)
        else $error("value on non-number token");

    // An empty error token reports the first line at offset zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == K_EMPTY |-> line_number == 16'd1 && text_start == '0)
        else $error("empty error token with position");
`endif

endmodule
